// ===== hw/rtl/gsb_pkg.sv =====
// ----------------------------------------------------------------------------
// gsb_pkg
// Shared constants for the grid shortest bridge block.
// ----------------------------------------------------------------------------
package gsb_pkg;
	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_MAX_COLS = 32;
	localparam int DIM_W = 6;
	localparam int LEVEL_W = 6;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 6'd63;

	localparam logic [1:0] CM_WATER = 2'd0;
	localparam logic [1:0] CM_LAND = 2'd1;
	localparam logic [1:0] CM_ISL1 = 2'd2;
	localparam logic [1:0] CM_ISL2 = 2'd3;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;
endpackage

// ===== hw/rtl/grid_shortest_bridge.sv =====
// ----------------------------------------------------------------------------
// grid_shortest_bridge
// Top level: configuration registers and the search engine.
// ----------------------------------------------------------------------------
// Cells load one per beat while busy is low. The beat with last_cell starts
// the search: a pass over the unloaded tail of the grid to mark it as water, a
// clear of the whole visited map (done twice), raster scans to find each island
// and to seed the BFS, and a final minimum scan. Every cell taken off the stack
// or the queue is split into row and column by a restoring divider, then each
// of the four directions is tried, with a further check for every neighbor
// inside the grid. The result appears with done, which is high for one cycle;
// the receiver cannot stall it. busy goes high after the last_cell beat and
// drops in the cycle of done.
module grid_shortest_bridge import gsb_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [DIM_W-1:0]   cfg_data,
	input  logic               start,
	input  logic               cell_is_land,
	input  logic               last_cell,
	output logic               busy,
	output logic               done,
	output logic [LEVEL_W-1:0] bridge_length,
	output logic               status
);
	logic [DIM_W-1:0] rows_q, cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(32);
			cols_q <= DIM_W'(32);
		end else if (cfg_we) begin
			if (cfg_index == REG_ROWS)
				rows_q <= cfg_data;
			else if (cfg_index == REG_COLS)
				cols_q <= cfg_data;
		end
	end

	gsb_engine #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_engine (
		.clk(clk), .arst_n(arst_n), .nr(rows_q), .nc(cols_q),
		.start(start), .cell_is_land(cell_is_land), .last_cell(last_cell),
		.busy(busy), .done(done), .bridge_length(bridge_length), .status(status)
	);
endmodule

// ===== hw/rtl/gsb_engine.sv =====
// ----------------------------------------------------------------------------
// gsb_engine
// Sequencer with the grid memories: load, two flood fills, BFS, minimum scan.
// ----------------------------------------------------------------------------
module gsb_engine import gsb_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DIM_W-1:0]   nr,
	input  logic [DIM_W-1:0]   nc,
	input  logic               start,
	input  logic               cell_is_land,
	input  logic               last_cell,
	output logic               busy,
	output logic               done,
	output logic [LEVEL_W-1:0] bridge_length,
	output logic               status
);
	localparam int CAP = MAX_ROWS * MAX_COLS;
	localparam int AW = $clog2(CAP);
	localparam int CW = $clog2(CAP + 1);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int KW = $clog2(MAX_COLS);
	localparam int DW = AW + RW;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PAD   = 4'd1;  // force unloaded cells to water
	localparam logic [3:0] ST_SCAN  = 4'd2;  // find first land cell
	localparam logic [3:0] ST_SCANW = 4'd3;
	localparam logic [3:0] ST_POP   = 4'd4;
	localparam logic [3:0] ST_NB    = 4'd5;  // issue neighbor read
	localparam logic [3:0] ST_NBW   = 4'd6;  // check neighbor
	localparam logic [3:0] ST_SEED  = 4'd7;  // BFS seed scan
	localparam logic [3:0] ST_SEEDW = 4'd8;
	localparam logic [3:0] ST_BPOP  = 4'd9;
	localparam logic [3:0] ST_BPOPW = 4'd10;
	localparam logic [3:0] ST_MIN   = 4'd11;
	localparam logic [3:0] ST_MINW  = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;
	localparam logic [3:0] ST_CLR   = 4'd14; // clear visited map
	localparam logic [3:0] ST_DIV   = 4'd15; // split index into row and column

	logic [1:0]         cell_mem [CAP];
	logic [LEVEL_W-1:0] dist_mem [CAP];
	logic               vis_mem  [CAP];
	logic [AW-1:0]      stk_mem  [CAP];
	logic [AW-1:0]      que_mem  [CAP];

	logic [3:0]  state_q, ret_q;
	logic [CW-1:0] load_q, idx_q, n_q, sp_q, head_q, tail_q;
	logic          isl_q;       // 0 first island, 1 second
	logic          bfs_q;
	logic [AW-1:0] p_q, q_q;
	logic [RW-1:0] pr_q;
	logic [KW-1:0] pc_q;
	logic [1:0]    d_q;
	logic [LEVEL_W-1:0] lv_q, best_q;
	logic [1:0]    cell_rd_q;
	logic [LEVEL_W-1:0] dist_rd_q;
	logic          vis_rd_q;
	logic [AW-1:0] stk_rd_q, que_rd_q;
	logic [6:0]    best_w;

	logic [AW-1:0] div_rem_q, div_rem_nx;
	logic [DW-1:0] div_den_q;
	logic [RW-1:0] div_cnt_q;
	logic          div_take;

	logic [AW-1:0] nr_a, nc_a;
	logic [CW-1:0] nr_n, nc_n;
	logic          nb_ok;
	logic [AW-1:0] nb_idx;
	logic          rd_sel;

	// effective dimensions
	always_comb begin
		nr_n = (nr == '0) ? CW'(1) : ((CW'(nr) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(nr));
		nc_n = (nc == '0) ? CW'(1) : ((CW'(nc) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(nc));
		nr_a = AW'(nr_n);
		nc_a = AW'(nc_n);
	end

	// one restoring step: compare and subtract the shifted column count
	always_comb begin
		div_take = (DW'(div_rem_q) >= div_den_q);
		div_rem_nx = div_take ? div_rem_q - div_den_q[AW-1:0] : div_rem_q;
	end

	// neighbor of p in direction d: up, left, right, down
	always_comb begin
		nb_ok = 1'b0;
		nb_idx = p_q;
		unique case (d_q)
			2'd0: begin
				nb_ok = (pr_q != '0);
				nb_idx = p_q - nc_a;
			end
			2'd1: begin
				nb_ok = (pc_q != '0);
				nb_idx = p_q - AW'(1);
			end
			2'd2: begin
				nb_ok = (CW'(pc_q) + CW'(1) < nc_n);
				nb_idx = p_q + AW'(1);
			end
			default: begin
				nb_ok = (CW'(pr_q) + CW'(1) < nr_n);
				nb_idx = p_q + nc_a;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign rd_sel = 1'b0;
	assign best_w = {1'b0, best_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start && load_q < CW'(CAP))
			cell_mem[load_q[AW-1:0]] <= {1'b0, cell_is_land};
		else if (state_q == ST_PAD && idx_q < n_q)
			cell_mem[idx_q[AW-1:0]] <= CM_WATER;
		else if (state_q == ST_POP)
			cell_mem[stk_rd_q] <= isl_q ? CM_ISL2 : CM_ISL1;
		cell_rd_q <= cell_mem[(state_q == ST_NB) ? nb_idx :
			(state_q == ST_MIN) ? idx_q[AW-1:0] : idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			load_q <= '0;
			idx_q <= '0;
			n_q <= '0;
			sp_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			isl_q <= 1'b0;
			bfs_q <= 1'b0;
			done <= 1'b0;
			status <= 1'b0;
			bridge_length <= '0;
			lv_q <= '0;
			best_q <= '0;
			d_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (load_q < CW'(CAP))
							load_q <= load_q + CW'(1);
						if (last_cell) begin
							idx_q <= (load_q < CW'(CAP)) ? load_q + CW'(1) : load_q;
							n_q <= CW'(nr_n * nc_n);
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (idx_q < n_q)
						idx_q <= idx_q + CW'(1);
					else begin
						idx_q <= '0;
						isl_q <= 1'b0;
						ret_q <= ST_SCAN;
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					vis_mem[idx_q[AW-1:0]] <= 1'b0;
					if (idx_q == CW'(CAP - 1)) begin
						idx_q <= '0;
						state_q <= ret_q;
					end else
						idx_q <= idx_q + CW'(1);
				end
				ST_SCAN: begin
					if (idx_q >= n_q) begin
						status <= 1'b1;
						bridge_length <= '0;
						state_q <= ST_DONE;
					end else
						state_q <= ST_SCANW;
				end
				ST_SCANW: begin
					if (cell_rd_q == CM_LAND) begin
						vis_mem[idx_q[AW-1:0]] <= 1'b1;
						stk_mem[0] <= idx_q[AW-1:0];
						sp_q <= CW'(1);
						state_q <= ST_BPOP;
						bfs_q <= 1'b0;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_BPOP: begin
					// read the top of the stack or head of the queue
					if (!bfs_q) begin
						if (sp_q == '0) begin
							idx_q <= '0;
							if (isl_q) begin
								ret_q <= ST_SEED;
								state_q <= ST_CLR;
								tail_q <= '0;
							end else begin
								isl_q <= 1'b1;
								state_q <= ST_SCAN;
							end
						end else begin
							stk_rd_q <= stk_mem[sp_q[AW-1:0] - AW'(1)];
							sp_q <= sp_q - CW'(1);
							state_q <= ST_POP;
						end
					end else begin
						if (head_q == tail_q) begin
							idx_q <= '0;
							best_q <= LEVEL_MAX;
							state_q <= ST_MIN;
						end else begin
							que_rd_q <= que_mem[head_q[AW-1:0]];
							head_q <= head_q + CW'(1);
							state_q <= ST_BPOPW;
						end
					end
				end
				ST_POP: begin
					p_q <= stk_rd_q;
					div_rem_q <= stk_rd_q;
					div_den_q <= DW'(nc_a) << (RW - 1);
					div_cnt_q <= RW'(RW - 1);
					pr_q <= '0;
					d_q <= '0;
					state_q <= ST_DIV;
				end
				ST_BPOPW: begin
					p_q <= que_rd_q;
					div_rem_q <= que_rd_q;
					div_den_q <= DW'(nc_a) << (RW - 1);
					div_cnt_q <= RW'(RW - 1);
					pr_q <= '0;
					lv_q <= (dist_mem[que_rd_q] == LEVEL_MAX) ? LEVEL_MAX
						: dist_mem[que_rd_q] + LEVEL_W'(1);
					d_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// row collects quotient bits, column ends as the remainder
					div_rem_q <= div_rem_nx;
					div_den_q <= div_den_q >> 1;
					pr_q <= RW'({pr_q, div_take});
					pc_q <= KW'(div_rem_nx);
					if (div_cnt_q == '0)
						state_q <= ST_NB;
					else
						div_cnt_q <= div_cnt_q - RW'(1);
				end
				ST_NB: begin
					q_q <= nb_idx;
					vis_rd_q <= vis_mem[nb_idx];
					if (nb_ok)
						state_q <= ST_NBW;
					else begin
						if (d_q == 2'd3)
							state_q <= ST_BPOP;
						d_q <= d_q + 2'd1;
					end
				end
				ST_NBW: begin
					if (!vis_rd_q && (bfs_q || cell_rd_q == CM_LAND)) begin
						vis_mem[q_q] <= 1'b1;
						if (bfs_q) begin
							dist_mem[q_q] <= lv_q;
							que_mem[tail_q[AW-1:0]] <= q_q;
							tail_q <= tail_q + CW'(1);
						end else begin
							stk_mem[sp_q[AW-1:0]] <= q_q;
							sp_q <= sp_q + CW'(1);
						end
					end
					d_q <= d_q + 2'd1;
					state_q <= (d_q == 2'd3) ? ST_BPOP : ST_NB;
				end
				ST_SEED: begin
					if (idx_q >= n_q) begin
						bfs_q <= 1'b1;
						head_q <= '0;
						state_q <= ST_BPOP;
					end else
						state_q <= ST_SEEDW;
				end
				ST_SEEDW: begin
					if (cell_rd_q == CM_ISL1) begin
						vis_mem[idx_q[AW-1:0]] <= 1'b1;
						dist_mem[idx_q[AW-1:0]] <= '0;
						que_mem[tail_q[AW-1:0]] <= idx_q[AW-1:0];
						tail_q <= tail_q + CW'(1);
					end
					idx_q <= idx_q + CW'(1);
					state_q <= ST_SEED;
				end
				ST_MIN: begin
					if (idx_q >= n_q) begin
						status <= 1'b0;
						bridge_length <= (best_q == LEVEL_MAX) ? LEVEL_MAX :
							((best_q == '0) ? '0 : best_q - LEVEL_W'(1));
						state_q <= ST_DONE;
					end else begin
						dist_rd_q <= dist_mem[idx_q[AW-1:0]];
						state_q <= ST_MINW;
					end
				end
				ST_MINW: begin
					if (cell_rd_q == CM_ISL2 && {1'b0, dist_rd_q} < best_w && !rd_sel)
						best_q <= dist_rd_q;
					idx_q <= idx_q + CW'(1);
					state_q <= ST_MIN;
				end
				ST_DONE: begin
					done <= 1'b1;
					load_q <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
